@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ hw/rtl/chacha_pkg.sv @@
`timescale 1ns / 1ps

package chacha_pkg;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  // Four half quarter-round steps make one double round.
  localparam int unsigned STEP_COUNT = 4 * DOUBLE_ROUNDS;
  localparam int unsigned STEP_W = $clog2(STEP_COUNT);

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef logic [31:0] word_t;
  typedef logic [3:0][31:0] quad_t;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PAIR_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_0     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_1     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_2     = 3'd6;

  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  localparam word_t NONCE_0_RST = 32'h0011_2233;
  localparam word_t NONCE_1_RST = 32'h4455_6677;
  localparam word_t NONCE_2_RST = 32'h8899_AABB;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // item needs a fresh block: load the working state
    logic direct;  // item uses the current block: produce its result now
    logic step;    // one half quarter-round step on all four columns
    logic diag;    // step belongs to a diagonal round
    logic half;    // second half of the quarter round (rotations 8 and 7)
    logic feed;    // feed-forward addition into the keystream block
    logic emit;    // produce the result of the held item
  } cmd_t;

  typedef struct packed {
    logic ks_ready;
  } status_t;

  // Half of a quarter round: two dependent additions with their XOR and rotate.
  function automatic quad_t qr_half(quad_t v, logic second);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    quad_t r;
    a = v[0] + v[1];
    d = v[3] ^ a;
    d = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
    c = v[2] + d;
    b = v[1] ^ c;
    b = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
    r[0] = a;
    r[1] = b;
    r[2] = c;
    r[3] = d;
    return r;
  endfunction

endpackage

@@ hw/rtl/chacha_ctrl.sv @@
`timescale 1ns / 1ps

module chacha_ctrl import chacha_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    msg_start_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  logic              out_free;
  logic              accept;
  logic              need_block;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign need_block  = msg_start_i || !status_i.ks_ready;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = accept && need_block;
    cmd_o.direct = accept && !need_block;
    cmd_o.step   = (state_q == ST_ROUND);
    cmd_o.half   = step_q[0];
    cmd_o.diag   = step_q[1];
    cmd_o.feed   = (state_q == ST_FEED);
    cmd_o.emit   = (state_q == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.direct || cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.load) begin
            state_q <= ST_ROUND;
            step_q  <= '0;
          end
        end
        ST_ROUND: begin
          if (step_q == STEP_W'(STEP_COUNT - 1)) begin
            state_q <= ST_FEED;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_FEED: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/chacha_dp.sv @@
`timescale 1ns / 1ps

module chacha_dp import chacha_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  msg_start_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic [7:0]            out_byte_o
);

  logic [63:0] key_q [4];
  word_t       nonce_q [3];
  word_t       counter_q;
  logic [5:0]  pos_q;
  logic        ks_ready_q;
  word_t       x_q [16];
  word_t       ks_q [16];
  logic [7:0]  data_q;
  logic [7:0]  out_byte_q;

  word_t       ctr_sel;
  logic [5:0]  pos_sel;
  word_t       init_w [16];
  word_t       col_nx [16];
  word_t       diag_nx [16];
  word_t       ks_word;
  logic [7:0]  ks_byte;
  logic [7:0]  src_byte;
  quad_t       q_in;
  quad_t       q_out;

  assign ctr_sel = (cmd_i.load && msg_start_i) ? '0 : counter_q;
  assign pos_sel = (cmd_i.load && msg_start_i) ? '0 : pos_q;

  always_comb begin
    init_w[0]  = SIGMA_0;
    init_w[1]  = SIGMA_1;
    init_w[2]  = SIGMA_2;
    init_w[3]  = SIGMA_3;
    for (int k = 0; k < 4; k++) begin
      init_w[4 + 2 * k] = key_q[k][31:0];
      init_w[5 + 2 * k] = key_q[k][63:32];
    end
    init_w[12] = ctr_sel;
    init_w[13] = nonce_q[0];
    init_w[14] = nonce_q[1];
    init_w[15] = nonce_q[2];
  end

  // Column and diagonal forms of the step; the controller says which applies.
  always_comb begin
    q_in  = '0;
    q_out = '0;
    for (int i = 0; i < 16; i++) begin
      col_nx[i]  = x_q[i];
      diag_nx[i] = x_q[i];
    end
    for (int q = 0; q < 4; q++) begin
      q_in[0] = x_q[q];
      q_in[1] = x_q[4 + q];
      q_in[2] = x_q[8 + q];
      q_in[3] = x_q[12 + q];
      q_out = qr_half(q_in, cmd_i.half);
      col_nx[q]      = q_out[0];
      col_nx[4 + q]  = q_out[1];
      col_nx[8 + q]  = q_out[2];
      col_nx[12 + q] = q_out[3];
      q_in[0] = x_q[q];
      q_in[1] = x_q[4 + ((q + 1) % 4)];
      q_in[2] = x_q[8 + ((q + 2) % 4)];
      q_in[3] = x_q[12 + ((q + 3) % 4)];
      q_out = qr_half(q_in, cmd_i.half);
      diag_nx[q]                  = q_out[0];
      diag_nx[4 + ((q + 1) % 4)]  = q_out[1];
      diag_nx[8 + ((q + 2) % 4)]  = q_out[2];
      diag_nx[12 + ((q + 3) % 4)] = q_out[3];
    end
  end

  assign ks_word  = ks_q[pos_q[5:2]];
  assign ks_byte  = ks_word[{pos_q[1:0], 3'b000} +: 8];
  assign src_byte = cmd_i.emit ? data_q : data_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        key_q[k] <= '0;
      end
      nonce_q[0] <= NONCE_0_RST;
      nonce_q[1] <= NONCE_1_RST;
      nonce_q[2] <= NONCE_2_RST;
      counter_q  <= '0;
      pos_q      <= '0;
      ks_ready_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_KEY_PAIR_0: key_q[0]   <= cfg_data_i;
          CFG_KEY_PAIR_1: key_q[1]   <= cfg_data_i;
          CFG_KEY_PAIR_2: key_q[2]   <= cfg_data_i;
          CFG_KEY_PAIR_3: key_q[3]   <= cfg_data_i;
          CFG_NONCE_0:    nonce_q[0] <= cfg_data_i[31:0];
          CFG_NONCE_1:    nonce_q[1] <= cfg_data_i[31:0];
          CFG_NONCE_2:    nonce_q[2] <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        counter_q  <= ctr_sel;
        pos_q      <= pos_sel;
        ks_ready_q <= 1'b0;
      end else if (cmd_i.feed) begin
        ks_ready_q <= 1'b1;
      end else if (cmd_i.direct || cmd_i.emit) begin
        pos_q <= pos_q + 6'd1;
        if (pos_q == 6'd63) begin
          counter_q  <= counter_q + 32'd1;
          ks_ready_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      data_q <= data_byte_i;
      for (int i = 0; i < 16; i++) begin
        x_q[i] <= init_w[i];
      end
    end else if (cmd_i.step) begin
      for (int i = 0; i < 16; i++) begin
        x_q[i] <= cmd_i.diag ? diag_nx[i] : col_nx[i];
      end
    end
    if (cmd_i.feed) begin
      for (int i = 0; i < 16; i++) begin
        ks_q[i] <= x_q[i] + init_w[i];
      end
    end
    if (cmd_i.direct || cmd_i.emit) begin
      out_byte_q <= src_byte ^ ks_byte;
    end
  end

  assign status_o.ks_ready = ks_ready_q;
  assign out_byte_o        = out_byte_q;

endmodule

@@ hw/rtl/chacha20_stream_cipher_unit.sv @@
// Timing: an item that uses the current keystream block gives its result in the cycle after
// it is accepted; an item that needs a new block first runs all round steps, then the
// feed-forward, then forms its result in the emit state once the result register is free.
// Throughput: one item a cycle within a block while results are collected without stall.
// Reset (asynchronous, active low) clears the counter, the byte position and the
// block-valid flag and loads the key and nonce reset values.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module chacha20_stream_cipher_unit import chacha_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input items.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  msg_start_i,
  // Result items.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  // Register writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;
  logic    start_acc;
  logic    out_busy;

  // Register writes are always taken; the user must let them arrive only while the block
  // is idle, which it does not enforce; a new key or nonce takes effect at the next block generation.
  assign cfg_ready_o = 1'b1;

  // The controller sequences one item at a time. An item that opens a message, or that
  // arrives when the current block has been used up, first runs the round unit: each
  // cycle performs half of a quarter round on all four columns (or diagonals). The result
  // register sits in the datapath, and the next item is taken in the same cycle as a
  // waiting result is collected.
  chacha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .msg_start_i (msg_start_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the key and nonce registers, the block counter, the byte position,
  // the working state of the rounds and the finished keystream block. Keystream bytes are
  // taken little-endian within each word, word 0 first.
  chacha_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .data_byte_i (data_byte_i),
    .msg_start_i (msg_start_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_byte_o  (out_byte_o)
  );

  // An accepted item that opens a message, and a result that is held back this cycle.
  assign start_acc = in_valid_i && in_ready_o && msg_start_i;
  assign out_busy  = out_valid_o && !out_ready_i;

  // A finished feed-forward always leaves a valid keystream block behind.
  `ASSERT_NEXT(a_feed_sets_ready, clk_i, rst_ni, cmd.feed, status.ks_ready, "block not ready")
  // An item that opens a message always starts a block generation.
  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_acc, !in_ready_o, "start without block")
  // A result is only produced directly from a valid block.
  `ASSERT_PROP(a_direct_ready, clk_i, rst_ni, !cmd.direct || status.ks_ready, "no block")
  // A held result is never overwritten before it is collected.
  `ASSERT_PROP(a_no_overwrite, clk_i, rst_ni, !(cmd.emit && out_busy), "result overwritten")

endmodule
